FILE: src/looping_cue_timer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the looping cue timer
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOOPING_CUE_TIMER_CORE_MACROS_SVH
`define LOOPING_CUE_TIMER_CORE_MACROS_SVH

// Same-cycle implication.
`define LCT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Widths, command and result codes, and request types of the cue timer.
// ----------------------------------------------------------------------------
package lct_pkg;

	localparam int MAX_CUES  = 16;
	localparam int TIME_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int DUR_W     = 24;
	localparam int THR_W     = 16;
	localparam int CUE_W     = 16;
	localparam int CMD_W     = 3;
	localparam int KIND_W    = 2;
	localparam int IDX_W     = 4;
	localparam int ADDR_W    = (MAX_CUES > 1) ? $clog2(MAX_CUES) : 1;
	localparam int CNT_W     = $clog2(MAX_CUES + 1);
	localparam int STEP_W    = $clog2(TIME_BITS + 1);
	localparam int PROD_W    = CUE_W + DUR_W;
	localparam int REG_W     = 1;
	localparam int CFG_W     = DUR_W;

	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PLAY  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PAUSE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

	localparam logic [REG_W-1:0] REG_DURATION  = 1'b0;
	localparam logic [REG_W-1:0] REG_THRESHOLD = 1'b1;

	localparam logic [DUR_W-1:0] DURATION_RST  = DUR_W'(6000);
	localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(15);

	localparam logic [STEP_W-1:0] STEPS_MOD  = STEP_W'(TIME_BITS);
	localparam logic [STEP_W-1:0] STEPS_FRAC = STEP_W'(FRAC_BITS);

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [TIME_BITS-1:0] now_ms;
		logic [CUE_W-1:0]     cue_pos;
	} cmd_req_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [IDX_W-1:0]     cue_index;
		logic [DUR_W-1:0]     position_ms;
		logic [FRAC_BITS-1:0] position_frac;
		logic                 running;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic                 start;
		logic [STEP_W-1:0]    steps;
		logic [DUR_W-1:0]     r_init;
		logic [TIME_BITS-1:0] num_init;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DUR_W-1:0]     rem;
		logic [TIME_BITS-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic              add;
		logic              rd;
		logic              cmp;
		logic [ADDR_W-1:0] idx;
	} cue_ctl_t;

endpackage

FILE: src/looping_cue_timer_core.sv
// ----------------------------------------------------------------------------
// looping_cue_timer_core
// Looping millisecond timer with play, pause and stop that fires stored cues.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  command  | cmd_valid, cmd_stall, cmd_data   | in
//  result   | res_valid, res_stall, res_data   | out
//  config   | cfg_we, cfg_index, cfg_data      | in
//
// A tick while playing runs the loop modulo and then the fraction on the
// shared divider (one quotient bit per cycle: 32 steps for the loop modulo,
// 16 for the fraction), then the read, multiply and compare of each stored
// cue and a result per fired cue; every other command runs only the fraction.
// Reset clears all control state at once; there is no clearing pass.
// A stalled result holds in the output register; the sequencer waits there.
// ----------------------------------------------------------------------------
`include "looping_cue_timer_core_macros.svh"

module looping_cue_timer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  lct_pkg::cmd_req_t           cmd_data,
	output logic                        res_valid,
	input  logic                        res_stall,
	output lct_pkg::res_t               res_data,
	input  logic                        cfg_we,
	input  logic [lct_pkg::REG_W-1:0]   cfg_index,
	input  logic [lct_pkg::CFG_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_FRAC,
		ST_RD,
		ST_MUL,
		ST_CMP,
		ST_FIRE,
		ST_FINAL
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [lct_pkg::DUR_W-1:0] duration_q;
	logic [lct_pkg::THR_W-1:0] threshold_q;

	// Timer bookkeeping.
	logic [lct_pkg::TIME_BITS-1:0] start_q;
	logic [lct_pkg::TIME_BITS-1:0] pause_off_q;
	logic [lct_pkg::TIME_BITS-1:0] paused_tot_q;
	logic                          playing_q;
	logic [lct_pkg::DUR_W-1:0]     loop_time_q;
	logic [lct_pkg::FRAC_BITS-1:0] frac_q;
	logic                          frac_sat_q;
	logic                          tick_play_q;
	logic                          reject_q;
	logic [lct_pkg::ADDR_W-1:0]    idx_q;

	// Output register.
	logic          res_valid_q;
	lct_pkg::res_t res_q;

	logic                          cmd_acc;
	logic                          tick_play;
	logic                          slot_free;
	logic                          res_load;
	logic                          last_cue;
	logic [lct_pkg::DUR_W-1:0]     d_eff;
	logic [lct_pkg::DUR_W-1:0]     lt_init;
	logic [lct_pkg::TIME_BITS-1:0] since_start;
	logic [lct_pkg::TIME_BITS-1:0] elapsed;

	lct_pkg::div_req_t div_req;
	lct_pkg::div_rsp_t div_rsp;
	lct_pkg::cue_ctl_t cue_ctl;
	logic [lct_pkg::CNT_W-1:0] cue_count;
	logic                      cue_full;
	logic                      cue_hit;

	// Take a request only between commands.
	assign cmd_stall = state_q != ST_IDLE;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign tick_play = (cmd_data.cmd == lct_pkg::CMD_TICK) && playing_q;

	// Treat a zero loop length as one millisecond.
	assign d_eff = (duration_q == '0) ? lct_pkg::DUR_W'(1) : duration_q;

	assign since_start = cmd_data.now_ms - start_q;
	assign elapsed     = since_start - paused_tot_q;
	assign lt_init     = (cmd_data.cmd == lct_pkg::CMD_STOP) ? '0 : loop_time_q;

	assign slot_free = !res_valid_q || !res_stall;
	assign last_cue  = (lct_pkg::CNT_W'(idx_q) + 1'b1) == cue_count;
	// Load a result from the fire or final state once the output slot is free.
	assign res_load  = slot_free && ((state_q == ST_FIRE) || (state_q == ST_FINAL));

	// Start the modulo on a running tick, otherwise go straight to the
	// fraction; after the modulo, chain the fraction on its remainder.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.steps    = lct_pkg::STEPS_FRAC;
		div_req.r_init   = lt_init;
		div_req.num_init = '0;
		if (state_q == ST_IDLE) begin
			div_req.start = cmd_acc;
			if (tick_play) begin
				div_req.steps    = lct_pkg::STEPS_MOD;
				div_req.r_init   = '0;
				div_req.num_init = elapsed;
			end
		end else begin
			div_req.start  = (state_q == ST_MOD) && div_rsp.done;
			div_req.r_init = div_rsp.rem;
		end
	end

	always_comb begin
		cue_ctl.add = cmd_acc && (cmd_data.cmd == lct_pkg::CMD_ADD);
		cue_ctl.rd  = state_q == ST_RD;
		cue_ctl.cmp = state_q == ST_CMP;
		cue_ctl.idx = idx_q;
	end

	lct_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.divisor (d_eff),
		.rsp     (div_rsp)
	);

	lct_cue_store u_cues (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (cue_ctl),
		.add_pos   (cmd_data.cue_pos),
		.duration  (d_eff),
		.loop_time (loop_time_q),
		.threshold (threshold_q),
		.count     (cue_count),
		.full      (cue_full),
		.hit       (cue_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q  <= lct_pkg::DURATION_RST;
			threshold_q <= lct_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lct_pkg::REG_DURATION:  duration_q  <= cfg_data;
				lct_pkg::REG_THRESHOLD: threshold_q <= cfg_data[lct_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			start_q      <= '0;
			pause_off_q  <= '0;
			paused_tot_q <= '0;
			playing_q    <= 1'b0;
			loop_time_q  <= '0;
			frac_q       <= '0;
			frac_sat_q   <= 1'b0;
			tick_play_q  <= 1'b0;
			reject_q     <= 1'b0;
			idx_q        <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			// Raise valid on a new result; drop it once the far side takes it.
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						tick_play_q <= tick_play;
						reject_q    <= (cmd_data.cmd == lct_pkg::CMD_ADD) && cue_full;
						frac_sat_q  <= lt_init >= d_eff;
						unique case (cmd_data.cmd)
							lct_pkg::CMD_PLAY: begin
								if (!playing_q) begin
									if (pause_off_q == '0) begin
										start_q <= cmd_data.now_ms;
									end else begin
										paused_tot_q <= paused_tot_q + since_start - pause_off_q;
									end
									playing_q <= 1'b1;
								end
							end
							lct_pkg::CMD_PAUSE: begin
								if (playing_q) begin
									pause_off_q <= since_start;
								end
								playing_q <= 1'b0;
							end
							lct_pkg::CMD_STOP: begin
								playing_q    <= 1'b0;
								loop_time_q  <= '0;
								start_q      <= '0;
								pause_off_q  <= '0;
								paused_tot_q <= '0;
							end
							default: ;
						endcase
						state_q <= tick_play ? ST_MOD : ST_FRAC;
					end
				end
				ST_MOD: begin
					if (div_rsp.done) begin
						loop_time_q <= div_rsp.rem;
						frac_sat_q  <= 1'b0;
						state_q     <= ST_FRAC;
					end
				end
				ST_FRAC: begin
					if (div_rsp.done) begin
						frac_q  <= frac_sat_q ? '1 : div_rsp.quo[lct_pkg::FRAC_BITS-1:0];
						idx_q   <= '0;
						state_q <= (tick_play_q && cue_count != '0) ? ST_RD : ST_FINAL;
					end
				end
				ST_RD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cue_hit) begin
						state_q <= ST_FIRE;
					end else if (last_cue) begin
						state_q <= ST_FINAL;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIRE: begin
					if (slot_free) begin
						res_q.kind          <= lct_pkg::KIND_FIRE;
						res_q.cue_index     <= lct_pkg::IDX_W'(idx_q);
						res_q.position_ms   <= loop_time_q;
						res_q.position_frac <= frac_q;
						res_q.running       <= playing_q;
						res_q.last          <= 1'b0;
						if (last_cue) begin
							state_q <= ST_FINAL;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_FINAL: begin
					if (slot_free) begin
						res_q.kind          <= reject_q ? lct_pkg::KIND_REJECT
						                                : lct_pkg::KIND_STATUS;
						res_q.cue_index     <= '0;
						res_q.position_ms   <= loop_time_q;
						res_q.position_frac <= frac_q;
						res_q.running       <= playing_q;
						res_q.last          <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Never restart the divider while it is still iterating.
	`LCT_ASSERT_IMPL(a_div_idle_on_start, div_req.start, !div_rsp.busy, "divider restarted while busy")
	// A fired cue never ends a command; a status or reject always does.
	`LCT_ASSERT_IMPL(a_last_by_kind, res_valid, (res_data.kind == lct_pkg::KIND_FIRE) != res_data.last, "last flag does not match result kind")
	// An accepted request always leaves the idle state.
	`LCT_ASSERT_NEXT(a_busy_after_accept, cmd_acc, state_q != ST_IDLE, "request accepted but sequencer idle")
	// The cue count stays within the table.
	`LCT_ASSERT_IMPL(a_count_bound, 1'b1, cue_count <= lct_pkg::CNT_W'(lct_pkg::MAX_CUES), "cue count beyond table size")

endmodule

FILE: src/lct_divider.sv
// ----------------------------------------------------------------------------
// lct_divider
// Restoring divider, one quotient bit per cycle, shared by modulo and fraction.
// ----------------------------------------------------------------------------
module lct_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lct_pkg::div_req_t          req,
	input  logic [lct_pkg::DUR_W-1:0]  divisor,
	output lct_pkg::div_rsp_t          rsp
);

	logic [lct_pkg::DUR_W-1:0]     rem_q;
	logic [lct_pkg::TIME_BITS-1:0] num_q;
	logic [lct_pkg::STEP_W-1:0]    cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [lct_pkg::DUR_W:0]       trial;
	logic [lct_pkg::DUR_W:0]       diff;
	logic                          take;

	// Shift the next dividend bit into the partial remainder and try to subtract.
	assign trial = {rem_q, num_q[lct_pkg::TIME_BITS-1]};
	assign take  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lct_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.r_init;
			num_q <= req.num_init;
		end else if (busy_q) begin
			rem_q <= take ? diff[lct_pkg::DUR_W-1:0] : trial[lct_pkg::DUR_W-1:0];
			num_q <= {num_q[lct_pkg::TIME_BITS-2:0], take};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.quo  = num_q;

endmodule

FILE: src/lct_cue_store.sv
// ----------------------------------------------------------------------------
// lct_cue_store
// Cue table, fired marks and the read, multiply and compare path of a scan.
// ----------------------------------------------------------------------------
module lct_cue_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lct_pkg::cue_ctl_t           ctl,
	input  logic [lct_pkg::CUE_W-1:0]   add_pos,
	input  logic [lct_pkg::DUR_W-1:0]   duration,
	input  logic [lct_pkg::DUR_W-1:0]   loop_time,
	input  logic [lct_pkg::THR_W-1:0]   threshold,
	output logic [lct_pkg::CNT_W-1:0]   count,
	output logic                        full,
	output logic                        hit
);

	logic [lct_pkg::CUE_W-1:0]  cue_mem [lct_pkg::MAX_CUES];
	logic [lct_pkg::CUE_W-1:0]  rd_s1;
	logic [lct_pkg::PROD_W-1:0] prod_s2;
	logic [lct_pkg::MAX_CUES-1:0] fired_q;
	logic [lct_pkg::CNT_W-1:0]  count_q;
	logic [lct_pkg::DUR_W-1:0]  cue_ms;
	logic [lct_pkg::DUR_W-1:0]  cue_gap;
	logic [lct_pkg::DUR_W-1:0]  thr_ext;
	logic                       fired_keep;
	logic                       add_ok;

	assign full    = count_q == lct_pkg::CNT_W'(lct_pkg::MAX_CUES);
	assign count   = count_q;
	assign add_ok  = ctl.add && !full;
	assign thr_ext = lct_pkg::DUR_W'(threshold);

	// Cue time in ms is the Q0.16 position scaled by the loop length.
	assign cue_ms  = prod_s2[lct_pkg::CUE_W +: lct_pkg::DUR_W];
	assign cue_gap = (cue_ms > loop_time) ? (cue_ms - loop_time) : (loop_time - cue_ms);

	// Rearm far cues first, then fire near ones that are armed.
	assign fired_keep = fired_q[ctl.idx] && !(cue_gap > thr_ext);
	assign hit        = ctl.cmp && (cue_gap < thr_ext) && !fired_keep;

	always_ff @(posedge clk) begin
		if (add_ok) begin
			cue_mem[count_q[lct_pkg::ADDR_W-1:0]] <= add_pos;
		end
		if (ctl.rd) begin
			rd_s1 <= cue_mem[ctl.idx];
		end
		prod_s2 <= lct_pkg::PROD_W'(rd_s1) * lct_pkg::PROD_W'(duration);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q <= '0;
			count_q <= '0;
		end else begin
			if (add_ok) begin
				fired_q[count_q[lct_pkg::ADDR_W-1:0]] <= 1'b0;
				count_q <= count_q + 1'b1;
			end else if (ctl.cmp) begin
				fired_q[ctl.idx] <= hit || fired_keep;
			end
		end
	end

endmodule
